FILE: rtl/core/gat_pkg.sv
// gat_pkg: shared types and constants for the grouped argmax table.
// No dependencies; imported by gat_argmax and grouped_argmax_table.
`timescale 1ns / 1ps

package gat_pkg;

  localparam int ITEM_W  = 10;
  localparam int GROUP_W = 4;
  localparam int SCORE_W = 27;

  localparam int ITEMS_DEF      = 1024;
  localparam int GROUPS_DEF     = 16;
  localparam int SCORE_BITS_DEF = 27;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_CHANGE = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHG,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_e;

  typedef struct packed {
    cmd_e                 cmd;
    logic [ITEM_W-1:0]    item;
    logic [GROUP_W-1:0]   group;
    logic [SCORE_W-1:0]   score;
  } gat_in_t;

  typedef struct packed {
    logic [ITEM_W-1:0] best_item;
    logic              found;
  } gat_out_t;

  typedef struct packed {
    logic clear;
    logic sample;
  } scan_ctl_t;

endpackage

FILE: rtl/core/gat_argmax.sv
// gat_argmax: running best-score register and compare unit used by a query scan.
// Depends on gat_pkg.
`timescale 1ns / 1ps

module gat_argmax #(
  parameter int ITEMS      = gat_pkg::ITEMS_DEF,
  parameter int SCORE_BITS = gat_pkg::SCORE_BITS_DEF,
  localparam int IDX_W     = $clog2(ITEMS)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  gat_pkg::scan_ctl_t    ctl_i,
  input  logic                  match_i,
  input  logic [SCORE_BITS-1:0] score_i,
  input  logic [IDX_W-1:0]      idx_i,
  output logic [IDX_W-1:0]      best_idx_o,
  output logic                  hit_o
);
  import gat_pkg::*;

  logic                  hit_q, hit_d;
  logic [IDX_W-1:0]      best_idx_q, best_idx_d;
  logic [SCORE_BITS-1:0] best_score_q, best_score_d;

  always_comb begin
    hit_d        = hit_q;
    best_idx_d   = best_idx_q;
    best_score_d = best_score_q;
    if (ctl_i.clear) begin
      hit_d = 1'b0;
    end else if (ctl_i.sample && match_i && (!hit_q || (score_i > best_score_q))) begin
      hit_d        = 1'b1;
      best_idx_d   = idx_i;
      best_score_d = score_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_idx_q   <= best_idx_d;
    best_score_q <= best_score_d;
  end

  assign hit_o      = hit_q;
  assign best_idx_o = hit_q ? best_idx_q : '0;

endmodule

FILE: rtl/core/grouped_argmax_table.sv
// grouped_argmax_table: item table with group and score, best-of-group query.
// Load: next word may follow in the next cycle. Change: read-modify-write via ST_CHG.
// Query: one table read per cycle in ST_SCAN, then ST_DRAIN and ST_DONE (result strobe);
// the next word is accepted back in ST_IDLE. The receiver cannot stall the result.
// After reset a clearing pass writes every entry invalid, with busy high throughout.
// Depends on gat_pkg and gat_argmax.
`timescale 1ns / 1ps

module grouped_argmax_table #(
  parameter int ITEMS      = gat_pkg::ITEMS_DEF,
  parameter int GROUPS     = gat_pkg::GROUPS_DEF,
  parameter int SCORE_BITS = gat_pkg::SCORE_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  gat_pkg::gat_in_t  cmd_i,
  output logic              valid_o,
  output gat_pkg::gat_out_t res_o
);
  import gat_pkg::*;

  localparam int IDX_W = $clog2(ITEMS);
  localparam int MEM_W = 1 + GROUP_W + SCORE_BITS;

  state_e state_q, state_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;
  logic             pend_q, pend_d;
  logic [IDX_W-1:0] cmp_idx_q;

  logic [IDX_W-1:0]      req_idx_q, req_idx_d;
  logic [GROUP_W-1:0]    req_group_q, req_group_d;
  logic [SCORE_BITS-1:0] req_score_q, req_score_d;
  logic                  grp_ok_q, grp_ok_d;

  logic [MEM_W-1:0] mem_q [ITEMS];
  logic [MEM_W-1:0] rdata_q;
  logic             we;
  logic [IDX_W-1:0] waddr, raddr;
  logic [MEM_W-1:0] wdata;

  logic                  accept;
  logic                  item_ok, group_ok;
  logic [IDX_W-1:0]      in_idx;
  logic [SCORE_BITS-1:0] in_score;
  logic                  r_valid;
  logic [GROUP_W-1:0]    r_group;
  logic [SCORE_BITS-1:0] r_score;
  logic                  match;
  scan_ctl_t             scan_ctl;
  logic [IDX_W-1:0]      best_idx;
  logic                  hit;

  assign accept   = start && (state_q == ST_IDLE);
  assign item_ok  = 32'(cmd_i.item) < 32'(ITEMS);
  assign group_ok = 32'(cmd_i.group) < 32'(GROUPS);
  assign in_idx   = IDX_W'(32'(cmd_i.item));
  assign in_score = SCORE_BITS'(32'(cmd_i.score));

  assign r_valid = rdata_q[MEM_W-1];
  assign r_group = rdata_q[SCORE_BITS +: GROUP_W];
  assign r_score = rdata_q[SCORE_BITS-1:0];
  assign match   = r_valid && (r_group == req_group_q) && grp_ok_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    pend_d      = 1'b0;
    req_idx_d   = req_idx_q;
    req_group_d = req_group_q;
    req_score_d = req_score_q;
    grp_ok_d    = grp_ok_q;
    we          = 1'b0;
    waddr       = in_idx;
    wdata       = {1'b1, cmd_i.group, in_score};
    raddr       = in_idx;
    scan_ctl    = '{clear: 1'b0, sample: pend_q};
    busy        = 1'b1;
    valid_o     = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = cnt_q;
        wdata = '0;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == IDX_W'(ITEMS - 1)) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (accept) begin
          req_idx_d   = in_idx;
          req_group_d = cmd_i.group;
          req_score_d = in_score;
          grp_ok_d    = group_ok;
          unique case (cmd_i.cmd)
            CMD_LOAD: begin
              we = item_ok && group_ok;
            end
            CMD_CHANGE: begin
              if (item_ok) begin
                state_d = ST_CHG;
              end
            end
            CMD_QUERY: begin
              scan_ctl.clear = 1'b1;
              cnt_d          = '0;
              state_d        = ST_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      ST_CHG: begin
        we      = r_valid;
        waddr   = req_idx_q;
        wdata   = {1'b1, r_group, req_score_q};
        state_d = ST_IDLE;
      end
      ST_SCAN: begin
        raddr  = cnt_q;
        pend_d = 1'b1;
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == IDX_W'(ITEMS - 1)) begin
          cnt_d   = '0;
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        valid_o = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_idx_q   <= req_idx_d;
    req_group_q <= req_group_d;
    req_score_q <= req_score_d;
    grp_ok_q    <= grp_ok_d;
    cmp_idx_q   <= raddr;
  end

  // table: valid, group, score per entry
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  gat_argmax #(
    .ITEMS      (ITEMS),
    .SCORE_BITS (SCORE_BITS)
  ) u_argmax (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (scan_ctl),
    .match_i    (match),
    .score_i    (r_score),
    .idx_i      (cmp_idx_q),
    .best_idx_o (best_idx),
    .hit_o      (hit)
  );

  assign res_o.best_item = ITEM_W'(32'(best_idx));
  assign res_o.found     = hit;

endmodule

FILE: tb/tb_grouped_argmax_table.sv
// tb_grouped_argmax_table: self-checking bench for the grouped argmax table.
// Random bursts of load/change/query words are checked against an in-bench table model.
// Depends on gat_pkg and grouped_argmax_table.
`timescale 1ns / 1ps

module tb_grouped_argmax_table;
  import gat_pkg::*;

  localparam int N_ITEMS  = ITEMS_DEF;
  localparam int N_GROUPS = GROUPS_DEF;
  localparam int N_RANDOM = 520;
  localparam int MAX_GAP  = 24;
  localparam int WATCHDOG = 8 * (N_ITEMS + MAX_GAP + 8);

  localparam logic [1:0]         CMD_RSVD  = 2'd3;
  localparam logic [SCORE_W-1:0] SCORE_MAX = '1;
  localparam int                 SCORE_TOP = 100000000;

  logic     clk_i  = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start  = 1'b0;
  gat_in_t  cmd_i  = '0;
  logic     busy;
  logic     valid_o;
  gat_out_t res_o;

  grouped_argmax_table u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_i  (cmd_i),
    .valid_o(valid_o),
    .res_o  (res_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  gat_in_t  pending_q[$];
  gat_out_t best_q[$];

  logic               tbl_valid [N_ITEMS];
  logic [GROUP_W-1:0] tbl_group [N_ITEMS];
  logic [SCORE_W-1:0] tbl_score [N_ITEMS];

  int n_err = 0;
  int idle_cycles = 0;
  int burst_left;
  int gap_left;

  initial begin
    for (int i = 0; i < N_ITEMS; i++) tbl_valid[i] = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    n_err++;
  endtask

  function automatic gat_out_t best_of_group(input logic [GROUP_W-1:0] g);
    gat_out_t           r;
    logic [SCORE_W-1:0] top;
    r   = '0;
    top = '0;
    if (g < N_GROUPS) begin
      for (int i = 0; i < N_ITEMS; i++) begin
        if (tbl_valid[i] && tbl_group[i] == g && (!r.found || tbl_score[i] > top)) begin
          r.found     = 1'b1;
          r.best_item = i[ITEM_W-1:0];
          top         = tbl_score[i];
        end
      end
    end
    return r;
  endfunction

  task automatic track_word(input gat_in_t w);
    case (w.cmd)
      CMD_LOAD: begin
        if (w.item < N_ITEMS && w.group < N_GROUPS) begin
          tbl_valid[w.item] = 1'b1;
          tbl_group[w.item] = w.group;
          tbl_score[w.item] = w.score;
        end
      end
      CMD_CHANGE: begin
        if (w.item < N_ITEMS && tbl_valid[w.item]) tbl_score[w.item] = w.score;
      end
      CMD_QUERY: best_q.push_back(best_of_group(w.group));
      default: ;
    endcase
  endtask

  task automatic push_word(input logic [1:0] code, input int it, input int g,
                           input logic [SCORE_W-1:0] sc);
    gat_in_t w;
    w.cmd   = cmd_e'(code);
    w.item  = it[ITEM_W-1:0];
    w.group = g[GROUP_W-1:0];
    w.score = sc;
    pending_q.push_back(w);
  endtask

  function automatic int pick_item();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return $urandom_range(0, 31);
    if (sel < 7) return $urandom_range(N_ITEMS - 32, N_ITEMS - 1);
    return $urandom_range(0, N_ITEMS - 1);
  endfunction

  function automatic int pick_group();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, N_GROUPS - 1);
    return $urandom_range(0, 3);
  endfunction

  function automatic logic [SCORE_W-1:0] pick_score();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 3) return SCORE_W'($urandom_range(0, 7));
    if (sel < 4) return SCORE_W'($urandom());
    if (sel < 5) return ($urandom_range(0, 1) != 0) ? SCORE_MAX : '0;
    return SCORE_W'($urandom_range(1, SCORE_TOP));
  endfunction

  // driver: bursts of words with random gaps; a word is held until taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start      <= 1'b0;
      cmd_i      <= '0;
      burst_left = 1;
      gap_left   = 0;
    end else if (!start || !busy) begin
      if (gap_left > 0 || pending_q.size() == 0) begin
        if (gap_left > 0) gap_left--;
        start <= 1'b0;
      end else begin
        cmd_i <= pending_q.pop_front();
        start <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                   : $urandom_range(1, 8);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, MAX_GAP);
        end
      end
    end
  end

  // monitor: check results, track accepted words, watchdog
  always @(posedge clk_i) begin : monitor_p
    gat_out_t want;
    if (rst_ni) begin
      if (valid_o) begin
        if (best_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result item=%0d found=%0d",
                                    res_o.best_item, res_o.found));
        end else begin
          want = best_q.pop_front();
          if (res_o.found !== want.found)
            report_mismatch($sformatf("found: got %0b want %0b", res_o.found, want.found));
          if (res_o.best_item !== want.best_item)
            report_mismatch($sformatf("best_item: got %0d want %0d",
                                      res_o.best_item, want.best_item));
        end
      end
      if (start && !busy) track_word(cmd_i);
      if ((start && !busy) || valid_o) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
        $display("watchdog expired after %0d idle cycles", idle_cycles);
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin : stimulus_p
    logic loaded [N_ITEMS];
    int   loaded_list[$];
    int   n_effective;
    int   sel;
    int   it;
    int   g;
    for (int i = 0; i < N_ITEMS; i++) loaded[i] = 1'b0;
    n_effective = 0;

    // directed: empty groups, score extremes, ties, reload, stray change, reserved code
    push_word(CMD_QUERY,  0,           0,            '0);
    push_word(CMD_QUERY,  0,           N_GROUPS - 1, '0);
    push_word(CMD_LOAD,   0,           0,            '0);
    push_word(CMD_QUERY,  0,           0,            '0);
    push_word(CMD_LOAD,   N_ITEMS - 1, N_GROUPS - 1, SCORE_MAX);
    push_word(CMD_QUERY,  0,           N_GROUPS - 1, '0);
    push_word(CMD_LOAD,   5,           0,            '0);
    push_word(CMD_QUERY,  0,           0,            '0);
    push_word(CMD_LOAD,   3,           0,            SCORE_W'(SCORE_TOP));
    push_word(CMD_QUERY,  0,           0,            '0);
    push_word(CMD_CHANGE, 0,           0,            SCORE_MAX);
    push_word(CMD_QUERY,  0,           0,            '0);
    push_word(CMD_CHANGE, 7,           0,            SCORE_MAX);
    push_word(CMD_QUERY,  0,           0,            '0);
    push_word(CMD_LOAD,   3,           N_GROUPS - 1, SCORE_MAX);
    push_word(CMD_QUERY,  0,           N_GROUPS - 1, '0);
    push_word(CMD_QUERY,  0,           0,            '0);
    push_word(CMD_RSVD,   0,           0,            SCORE_MAX);
    push_word(CMD_LOAD,   512,         8,            SCORE_W'(1));
    push_word(CMD_CHANGE, 512,         10,           SCORE_W'(2));
    push_word(CMD_QUERY,  0,           8,            '0);
    push_word(CMD_CHANGE, N_ITEMS - 1, 0,            SCORE_W'(1));
    push_word(CMD_QUERY,  0,           N_GROUPS - 1, '0);
    foreach (loaded[i]) loaded[i] = (i == 0 || i == 3 || i == 5 || i == 512 || i == N_ITEMS - 1);
    loaded_list = '{0, 3, 5, 512, N_ITEMS - 1};

    while (n_effective < N_RANDOM) begin
      sel = $urandom_range(0, 99);
      if (sel < 3) begin
        push_word(CMD_RSVD, $urandom_range(0, N_ITEMS - 1), $urandom_range(0, N_GROUPS - 1),
                  pick_score());
      end else if (sel < 43) begin
        it = pick_item();
        g  = pick_group();
        if (!loaded[it]) begin
          loaded[it] = 1'b1;
          loaded_list.push_back(it);
        end
        push_word(CMD_LOAD, it, g, pick_score());
        n_effective++;
      end else if (sel < 75) begin
        if ($urandom_range(0, 6) != 0)
          it = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
        else
          it = $urandom_range(0, N_ITEMS - 1);
        push_word(CMD_CHANGE, it, $urandom_range(0, N_GROUPS - 1), pick_score());
        if (loaded[it]) n_effective++;
      end else begin
        push_word(CMD_QUERY, $urandom_range(0, N_ITEMS - 1), pick_group(), pick_score());
        n_effective++;
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_q.size() != 0 || start) @(posedge clk_i);
    while (best_q.size() != 0) @(posedge clk_i);
    repeat (N_ITEMS + 8) @(posedge clk_i);
    if (best_q.size() != 0)
      report_mismatch($sformatf("%0d query results never arrived", best_q.size()));

    if (n_err == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/gat_pkg.sv
rtl/core/gat_argmax.sv
rtl/core/grouped_argmax_table.sv
tb/tb_grouped_argmax_table.sv
